// File: design/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// width helpers shared by the vector normalise front end, lanes and top level
// ----------------------------------------------------------------------------
package vn_pkg;

	// width of the square of a component magnitude (magnitude up to 2^(w-1))
	function automatic int sq_width(input int w);
		return 2 * w - 1;
	endfunction

	// width of the sum of three squares
	function automatic int sum_width(input int w);
		return 2 * w + 1;
	endfunction

	// signed working width of the per-lane remainder and cross term
	function automatic int acc_width(input int w, input int f);
		return 2 * w + 2 * f + 5;
	endfunction

endpackage

// File: design/vector3_normalize_core.sv
// ----------------------------------------------------------------------------
// vector3_normalize_core
// unit vector of a 3d fixed-point vector, three quotient lanes in parallel
// ----------------------------------------------------------------------------
// each input item passes the square, merge, quotient lane and output registers in that order
// throughput: one item per cycle while the output is not stalled, set by the one-bit-per-stage quotient lanes
// the whole pipeline holds while a result waits on m_tready
// reset clears the stage valid bits and the output valid; data is not reset
module vector3_normalize_core #(
	parameter int IN_WIDTH      = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// vec_x, vec_y, vec_z from the lowest bit up, zero padded to bytes
	input  logic [((3*IN_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// unit_x, unit_y, unit_z from the lowest bit up, zero padded to bytes
	output logic [((3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
	// zero_length
	output logic m_tuser
);
	import vn_pkg::*;

	localparam int W     = IN_WIDTH;
	localparam int F     = OUT_FRAC_BITS;
	localparam int OW    = F + 2;
	localparam int OD_W  = ((3*OW+7)/8)*8;
	localparam int SQ_W  = sq_width(W);
	localparam int SUM_W = sum_width(W);
	localparam int DEPTH = F + 3;

	logic en;
	logic [DEPTH-1:0] vld_q;

	logic [SQ_W-1:0] sq_c [3];
	logic            neg_c [3];
	logic [SQ_W-1:0] sq_s1 [3];
	logic            neg_s1 [3];
	logic [SQ_W-1:0] sq_s2 [3];
	logic [SUM_W-1:0] sum_s2;
	logic [F:0]      quo [3];
	logic [OD_W-1:0] tdata_c;

	// sign and zero flag ride alongside the lanes
	logic [2:0] neg_line_q  [F+2];
	logic       zero_line_q [F+2];

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		vn_square #(.W(W)) u_sq (
			.raw    (s_tdata[i*W +: W]),
			.neg    (neg_c[i]),
			.mag_sq (sq_c[i])
		);

		vn_lane #(.W(W), .F(F)) u_lane (
			.clk    (clk),
			.en     (en),
			.mag_sq (sq_s2[i]),
			.sum_sq (sum_s2),
			.quo    (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i]  <= sq_c[i];
				neg_s1[i] <= neg_c[i];
				sq_s2[i]  <= sq_s1[i];
			end
			// merge: sum of the three lane squares
			sum_s2 <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);
			neg_line_q[0]  <= {neg_s1[2], neg_s1[1], neg_s1[0]};
			zero_line_q[0] <= (sq_s1[0] == '0) && (sq_s1[1] == '0) && (sq_s1[2] == '0);
			for (int k = 1; k < F + 2; k++) begin
				neg_line_q[k]  <= neg_line_q[k-1];
				zero_line_q[k] <= zero_line_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_q    <= {vld_q[DEPTH-2:0], s_tvalid};
			m_tvalid <= vld_q[DEPTH-1];
		end
	end

	always_comb begin
		tdata_c = '0;
		for (int i = 0; i < 3; i++) begin
			if (zero_line_q[F+1])
				tdata_c[i*OW +: OW] = '0;
			else if (neg_line_q[F+1][i])
				tdata_c[i*OW +: OW] = -OW'(quo[i]);
			else
				tdata_c[i*OW +: OW] = OW'(quo[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= tdata_c;
			m_tuser <= zero_line_q[F+1];
		end
	end

`ifndef SYNTHESIS
	a_zero_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == OD_W'(0))
		else $error("zero length item with nonzero components");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q) && m_tvalid)
		else $error("pipeline moved while output stalled");
`endif

endmodule

// File: design/vn_square.sv
// ----------------------------------------------------------------------------
// vn_square
// magnitude, sign and square of one two's complement component
// ----------------------------------------------------------------------------
module vn_square #(
	parameter int W = 16
) (
	input  logic [W-1:0]                 raw,
	output logic                         neg,
	output logic [vn_pkg::sq_width(W)-1:0] mag_sq
);
	import vn_pkg::*;

	localparam int SQ_W = sq_width(W);

	logic [W-1:0] mag;

	assign neg    = raw[W-1];
	// most negative value gives 2^(W-1), which still fits W unsigned bits
	assign mag    = neg ? (~raw + W'(1)) : raw;
	assign mag_sq = SQ_W'(mag * mag);

endmodule

// File: design/vn_lane.sv
// ----------------------------------------------------------------------------
// vn_lane
// one bit of rounded quotient m*2^F/sqrt(S) per pipeline stage
// ----------------------------------------------------------------------------
module vn_lane #(
	parameter int W = 16,
	parameter int F = 14
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [vn_pkg::sq_width(W)-1:0]  mag_sq,
	input  logic [vn_pkg::sum_width(W)-1:0] sum_sq,
	output logic [F:0]                      quo
);
	import vn_pkg::*;

	localparam int SUM_W = sum_width(W);
	localparam int ACC_W = acc_width(W, F);

	// rem = m^2*2^(2F+2) - (2q-1)^2*S, cross = (2q-1)*S
	logic signed [ACC_W-1:0] rem_in   [F+1];
	logic signed [ACC_W-1:0] cross_in [F+1];
	logic        [SUM_W-1:0] sum_in   [F+1];
	logic        [F:0]       quo_in   [F+1];

	logic signed [ACC_W-1:0] rem_s   [F+1];
	logic signed [ACC_W-1:0] cross_s [F+1];
	logic        [SUM_W-1:0] sum_s   [F+1];
	logic        [F:0]       quo_s   [F+1];

	assign rem_in[0]   = (ACC_W'(mag_sq) << (2 * F + 2)) - ACC_W'(sum_sq);
	assign cross_in[0] = -$signed(ACC_W'(sum_sq));
	assign sum_in[0]   = sum_sq;
	assign quo_in[0]   = '0;

	for (genvar k = 0; k <= F; k++) begin : g_bit
		localparam int Sh = F - k;
		logic signed [ACC_W-1:0] cand;

		if (k > 0) begin : g_link
			assign rem_in[k]   = rem_s[k-1];
			assign cross_in[k] = cross_s[k-1];
			assign sum_in[k]   = sum_s[k-1];
			assign quo_in[k]   = quo_s[k-1];
		end

		// trial bit: (t - 1/2) still at or below the exact quotient
		assign cand = rem_in[k] - (cross_in[k] <<< (Sh + 2))
			- $signed(ACC_W'(sum_in[k]) << (2 * Sh + 2));

		always_ff @(posedge clk) begin
			if (en) begin
				sum_s[k] <= sum_in[k];
				if (!cand[ACC_W-1]) begin
					rem_s[k]   <= cand;
					cross_s[k] <= cross_in[k] + $signed(ACC_W'(sum_in[k]) << (Sh + 1));
					quo_s[k]   <= quo_in[k] | ((F+1)'(1) << Sh);
				end else begin
					rem_s[k]   <= rem_in[k];
					cross_s[k] <= cross_in[k];
					quo_s[k]   <= quo_in[k];
				end
			end
		end
	end

	assign quo = quo_s[F];

endmodule
